>>> hw/rtl/rfpw_pkg.sv
// Shared types and constants for the pulse-width frame decoder.
`timescale 1ns / 1ps

package rfpw_pkg;

	localparam int unsigned RUN_W      = 8;
	localparam int unsigned IDLE_W     = 16;
	localparam int unsigned BIT_POS_W  = 3;
	localparam int unsigned BYTE_POS_W = 3;
	localparam int unsigned DATA_BYTES = 5;
	localparam int unsigned DATA_W     = 8 * DATA_BYTES;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ONE_RUN_MIN   = 3'd0,
		CFG_ONE_RUN_MAX   = 3'd1,
		CFG_ZERO_RUN_MIN  = 3'd2,
		CFG_ZERO_RUN_MAX  = 3'd3,
		CFG_SYNC_LOW_MIN  = 3'd4,
		CFG_SYNC_LOW_MAX  = 3'd5,
		CFG_SYNC_HIGH_MIN = 3'd6,
		CFG_SYNC_HIGH_MAX = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [RUN_W-1:0]  one_run_min;
		logic [RUN_W-1:0]  one_run_max;
		logic [RUN_W-1:0]  zero_run_min;
		logic [RUN_W-1:0]  zero_run_max;
		logic [IDLE_W-1:0] sync_low_min;
		logic [IDLE_W-1:0] sync_low_max;
		logic [IDLE_W-1:0] sync_high_min;
		logic [IDLE_W-1:0] sync_high_max;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		one_run_min:   8'd3,
		one_run_max:   8'd7,
		zero_run_min:  8'd7,
		zero_run_max:  8'd15,
		sync_low_min:  16'd80,
		sync_low_max:  16'd160,
		sync_high_min: 16'd80,
		sync_high_max: 16'd1600
	};

	// Decoder control state, frame bytes kept apart
	typedef struct packed {
		logic [RUN_W-1:0]      bit_low_run;
		logic                  high_seen;
		logic                  synced;
		logic [IDLE_W-1:0]     idle_high_run;
		logic [IDLE_W-1:0]     idle_low_run;
		logic [BIT_POS_W-1:0]  bit_position;
		logic [BYTE_POS_W-1:0] byte_position;
		logic                  ready_flag;
	} dec_state_t;

	typedef struct packed {
		logic              frame_ready;
		logic [DATA_W-1:0] frame_data;
		logic              in_sync;
	} result_t;

endpackage

>>> hw/rtl/rf_pulse_width_frame_decoder_core.sv
// Top level of the pulse-width OOK frame decoder.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------------------
//   in       | in_valid / in_ready         | rf_level, powered, release_frame
//   out      | out_valid / out_ready       | frame_ready, frame_data, in_sync
//   cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// One sample request is taken per clock while in_ready is high; its result
// enters the buffer at that edge and shows next cycle if the main slot is free.
// All decoding is one combinational pass on the state registers.
// The two-entry output buffer drops in_ready only when both slots hold results.
// Reset loads the register defaults and clears all decoder state; no sweep.
// cfg_ready stays high; writes take effect on the next sample.
`timescale 1ns / 1ps

module rf_pulse_width_frame_decoder_core #(
	parameter int unsigned FRAME_BYTES = 5
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 rf_level,
	input  logic                                 powered,
	input  logic                                 release_frame,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 frame_ready,
	output logic [rfpw_pkg::DATA_W-1:0]          frame_data,
	output logic                                 in_sync,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rfpw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rfpw_pkg::CFG_DATA_W-1:0]      cfg_data
);

	rfpw_pkg::cfg_t             cfg_q;
	rfpw_pkg::dec_state_t       state_q;
	rfpw_pkg::dec_state_t       state_nxt;
	logic [FRAME_BYTES-1:0][7:0] store_q;
	logic [FRAME_BYTES-1:0][7:0] store_nxt;
	rfpw_pkg::result_t          res;
	rfpw_pkg::result_t          out_data;
	logic                       in_fire;
	logic                       space;

	assign cfg_ready = 1'b1;
	assign in_ready  = space;
	assign in_fire   = in_valid & space;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rfpw_pkg::CFG_RESET;
		end else if (cfg_valid) begin
			unique case (rfpw_pkg::cfg_idx_t'(cfg_index))
				rfpw_pkg::CFG_ONE_RUN_MIN:   cfg_q.one_run_min   <= cfg_data[7:0];
				rfpw_pkg::CFG_ONE_RUN_MAX:   cfg_q.one_run_max   <= cfg_data[7:0];
				rfpw_pkg::CFG_ZERO_RUN_MIN:  cfg_q.zero_run_min  <= cfg_data[7:0];
				rfpw_pkg::CFG_ZERO_RUN_MAX:  cfg_q.zero_run_max  <= cfg_data[7:0];
				rfpw_pkg::CFG_SYNC_LOW_MIN:  cfg_q.sync_low_min  <= cfg_data;
				rfpw_pkg::CFG_SYNC_LOW_MAX:  cfg_q.sync_low_max  <= cfg_data;
				rfpw_pkg::CFG_SYNC_HIGH_MIN: cfg_q.sync_high_min <= cfg_data;
				rfpw_pkg::CFG_SYNC_HIGH_MAX: cfg_q.sync_high_max <= cfg_data;
				default: ;
			endcase
		end
	end

	rfpw_step #(
		.FRAME_BYTES (FRAME_BYTES)
	) u_step (
		.cur           (state_q),
		.store_cur     (store_q),
		.cfg           (cfg_q),
		.rf_level      (rf_level),
		.powered       (powered),
		.release_frame (release_frame),
		.nxt           (state_nxt),
		.store_nxt     (store_nxt),
		.res           (res)
	);

	// Hold decoder state between accepted samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			store_q <= '0;
		end else if (in_fire) begin
			state_q <= state_nxt;
			store_q <= store_nxt;
		end
	end

	rfpw_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_fire),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign frame_ready = out_data.frame_ready;
	assign frame_data  = out_data.frame_data;
	assign in_sync     = out_data.in_sync;

endmodule

>>> hw/rtl/rfpw_step.sv
// Next-state and result logic for one receiver sample.
`timescale 1ns / 1ps

module rfpw_step #(
	parameter int unsigned FRAME_BYTES = 5
) (
	input  rfpw_pkg::dec_state_t       cur,
	input  logic [FRAME_BYTES-1:0][7:0] store_cur,
	input  rfpw_pkg::cfg_t             cfg,
	input  logic                       rf_level,
	input  logic                       powered,
	input  logic                       release_frame,
	output rfpw_pkg::dec_state_t       nxt,
	output logic [FRAME_BYTES-1:0][7:0] store_nxt,
	output rfpw_pkg::result_t          res
);

	logic push;
	logic push_one;
	logic enter;
	logic is_one;
	logic is_zero;

	// Bit windows on the low run before a rising edge
	assign is_one  = (cur.bit_low_run > cfg.one_run_min) &&
		(cur.bit_low_run <= cfg.one_run_max);
	assign is_zero = (cur.bit_low_run > cfg.zero_run_min) &&
		(cur.bit_low_run < cfg.zero_run_max);

	// Advance decoder state by one sample
	always_comb begin
		nxt       = cur;
		store_nxt = store_cur;
		push      = 1'b0;
		push_one  = 1'b0;
		enter     = 1'b0;
		nxt.ready_flag = cur.ready_flag & ~release_frame;
		if (!powered) begin
			nxt       = '0;
			store_nxt = '0;
		end else if (!nxt.ready_flag) begin
			// synchronized: measure low runs, decode at rising edges
			if (cur.synced) begin
				if (!rf_level) begin
					if (cur.bit_low_run != '1) begin
						nxt.bit_low_run = cur.bit_low_run + 1'b1;
					end
					nxt.high_seen = 1'b0;
				end else begin
					if (!cur.high_seen) begin
						if (is_one || is_zero) begin
							push     = 1'b1;
							push_one = is_one;
							if (cur.bit_position == rfpw_pkg::BIT_POS_W'(7)) begin
								nxt.bit_position = '0;
								if (cur.byte_position ==
										rfpw_pkg::BYTE_POS_W'(FRAME_BYTES - 1)) begin
									nxt.byte_position = '0;
									nxt.synced        = 1'b0;
									nxt.ready_flag    = 1'b1;
								end else begin
									nxt.byte_position = cur.byte_position + 1'b1;
								end
							end else begin
								nxt.bit_position = cur.bit_position + 1'b1;
							end
						end else begin
							nxt.synced        = 1'b0;
							nxt.bit_position  = '0;
							nxt.byte_position = '0;
						end
					end
					nxt.bit_low_run = '0;
					nxt.high_seen   = 1'b1;
				end
			end
			// unsynchronized, also on the sample that dropped sync
			if (!nxt.synced) begin
				if (rf_level) begin
					if (nxt.idle_high_run != '1) begin
						nxt.idle_high_run = nxt.idle_high_run + 1'b1;
					end
					enter = (nxt.idle_low_run > cfg.sync_low_min) &&
						(nxt.idle_low_run < cfg.sync_low_max);
					nxt.idle_low_run = '0;
				end else begin
					if (nxt.idle_low_run != '1) begin
						nxt.idle_low_run = nxt.idle_low_run + 1'b1;
					end
					enter = (nxt.idle_high_run > cfg.sync_high_min) &&
						(nxt.idle_high_run < cfg.sync_high_max);
					nxt.idle_high_run = '0;
				end
				if (enter) begin
					nxt.synced        = 1'b1;
					nxt.bit_position  = '0;
					nxt.byte_position = '0;
					nxt.idle_high_run = '0;
					nxt.idle_low_run  = '0;
					nxt.bit_low_run   = '0;
				end
			end
			// shift the new bit in at the top of the current byte
			for (int i = 0; i < FRAME_BYTES; i++) begin
				if (push && (cur.byte_position == rfpw_pkg::BYTE_POS_W'(i))) begin
					store_nxt[i] = {push_one, store_cur[i][7:1]};
				end
			end
		end
	end

	// Pack the result from the updated state
	assign res.frame_ready = nxt.ready_flag;
	assign res.in_sync     = nxt.synced;

	for (genvar g = 0; g < rfpw_pkg::DATA_BYTES; g++) begin : g_data
		if (g < FRAME_BYTES) begin : g_byte
			assign res.frame_data[8*g +: 8] = store_nxt[g];
		end else begin : g_pad
			assign res.frame_data[8*g +: 8] = 8'h00;
		end
	end

endmodule

>>> hw/rtl/rfpw_out_buf.sv
// Two-entry output buffer that keeps input ready off the output ready path.
`timescale 1ns / 1ps

module rfpw_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rfpw_pkg::result_t push_data,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output rfpw_pkg::result_t out_data
);

	logic              main_valid_q;
	logic              skid_valid_q;
	rfpw_pkg::result_t main_q;
	rfpw_pkg::result_t skid_q;
	logic              pop;

	assign pop       = main_valid_q & out_ready;
	assign space     = ~skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	// Track occupancy of both slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!push) begin
					main_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!main_valid_q) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	// Move result requests through the slots
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (!main_valid_q) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

>>> hw/rtl/rfpw_checker.sv
// Port-level checks for the frame decoder, bound to the top level.
`timescale 1ns / 1ps

module rfpw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            rf_level,
	input logic                            powered,
	input logic                            release_frame,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            frame_ready,
	input logic [rfpw_pkg::DATA_W-1:0]     frame_data,
	input logic                            in_sync,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [rfpw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [rfpw_pkg::CFG_DATA_W-1:0] cfg_data
);

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_data) &&
		$stable(frame_ready) && $stable(in_sync))
		else $error("result changed while stalled");

	// A held frame is never reported while synchronized
	a_ready_nosync: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(frame_ready && in_sync))
		else $error("frame_ready and in_sync both set");

	// Input back-pressure only with a result pending
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// Accepted request on an empty output shows a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> out_valid)
		else $error("accepted request produced no result");

endmodule

bind rf_pulse_width_frame_decoder_core rfpw_checker u_rfpw_checker (.*);
